[rtl/barometer_compensation_defines.svh]
// assertion macros for the barometer compensation rtl
// no dependencies; included by bcomp_pressure, the only module that carries checks
`ifndef BAROMETER_COMPENSATION_DEFINES_SVH
`define BAROMETER_COMPENSATION_DEFINES_SVH

// property checked on every clock outside reset
`define BCOMP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCOMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/bcomp_pkg.sv]
// beat types, calibration word layout and constants for barometer compensation
// no dependencies; imported by every module of the block
package bcomp_pkg;

    typedef enum logic [2:0] {
        CFG_PRESSURE_SENS   = 3'd0,
        CFG_PRESSURE_OFFSET = 3'd1,
        CFG_SENS_TEMPCO     = 3'd2,
        CFG_OFFSET_TEMPCO   = 3'd3,
        CFG_REF_TEMPERATURE = 3'd4,
        CFG_TEMP_SLOPE      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_beat;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [16:0]        pressure_centi_mbar;
        logic               clamped;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] pressure_sens;
        logic [15:0] pressure_offset;
        logic [15:0] sens_tempco;
        logic [15:0] offset_tempco;
        logic [15:0] ref_temperature;
        logic [15:0] temp_slope;
    } t_coef;

    // first-order results
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [19:0] temp;
        logic signed [18:0] dev;
        logic [16:0]        t2;
        logic signed [37:0] off;
        logic signed [37:0] sens;
    } t_base;

    // after second-order correction and temperature clamp
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [14:0] temp;
        logic               temp_clamped;
        logic signed [37:0] off;
        logic signed [37:0] sens;
    } t_corr;

    localparam logic [15:0] RST_PRESSURE_SENS   = 16'd40127;
    localparam logic [15:0] RST_PRESSURE_OFFSET = 16'd36924;
    localparam logic [15:0] RST_SENS_TEMPCO     = 16'd23317;
    localparam logic [15:0] RST_OFFSET_TEMPCO   = 16'd23282;
    localparam logic [15:0] RST_REF_TEMPERATURE = 16'd33464;
    localparam logic [15:0] RST_TEMP_SLOPE      = 16'd28312;

    localparam logic signed [19:0] TEMP_REF = 20'sd2000;
    localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
    localparam logic signed [19:0] TEMP_MAX = 20'sd8500;
    localparam logic signed [27:0] PRES_MIN = 28'sd1000;
    localparam logic signed [27:0] PRES_MAX = 28'sd120000;

endpackage

[rtl/bcomp_first_order.sv]
// first-order compensation: dT, then the four products, then TEMP, OFF, SENS and T2
// depends on bcomp_pkg
module bcomp_first_order
    import bcomp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    input  t_coef    i_coef,
    output logic     o_valid,
    output t_base    o_base
);

    logic [2:0]         r_v;
    logic [23:0]        r_d1_s1;
    logic signed [24:0] r_dt_s1;
    logic [23:0]        r_d1_s2;
    logic signed [41:0] r_p6;
    logic signed [41:0] r_p4;
    logic signed [41:0] r_p3;
    logic signed [49:0] r_pdd;
    t_base              r_base;

    logic signed [24:0] n_dt;
    logic signed [41:0] n_p6;
    logic signed [41:0] n_p4;
    logic signed [41:0] n_p3;
    logic signed [49:0] n_pdd;
    logic signed [18:0] n_dev;
    t_base              n_base;

    always_comb begin
        n_dt = $signed({1'b0, i_beat.raw_temperature})
             - $signed({1'b0, i_coef.ref_temperature, 8'h00});
    end

    always_comb begin
        n_p6  = 42'(r_dt_s1) * 42'($signed({1'b0, i_coef.temp_slope}));
        n_p4  = 42'(r_dt_s1) * 42'($signed({1'b0, i_coef.offset_tempco}));
        n_p3  = 42'(r_dt_s1) * 42'($signed({1'b0, i_coef.sens_tempco}));
        n_pdd = 50'(r_dt_s1) * 50'(r_dt_s1);
    end

    // bit-selects of the products are floor shifts
    always_comb begin
        n_dev       = r_p6[41:23];
        n_base.d1   = r_d1_s2;
        n_base.dev  = n_dev;
        n_base.temp = TEMP_REF + {n_dev[18], n_dev};
        n_base.off  = $signed({6'h00, i_coef.pressure_offset, 16'h0000})
                    + $signed({{3{r_p4[41]}}, r_p4[41:7]});
        n_base.sens = $signed({7'h00, i_coef.pressure_sens, 15'h0000})
                    + $signed({{4{r_p3[41]}}, r_p3[41:8]});
        n_base.t2   = r_pdd[47:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1_s1 <= i_beat.raw_pressure;
            r_dt_s1 <= n_dt;
            r_d1_s2 <= r_d1_s1;
            r_p6    <= n_p6;
            r_p4    <= n_p4;
            r_p3    <= n_p3;
            r_pdd   <= n_pdd;
            r_base  <= n_base;
        end
    end

    assign o_valid = r_v[2];
    assign o_base  = r_base;

endmodule

[rtl/bcomp_second_order.sv]
// cold-range correction: square of the deviation, T2/OFF2/SENS2, temperature clamp
// depends on bcomp_pkg
module bcomp_second_order
    import bcomp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_base i_base,
    output logic  o_valid,
    output t_corr o_corr
);

    logic [2:0]         r_v;
    t_base              r_base_s4;
    logic [34:0]        r_sq;
    t_base              r_base_s5;
    logic signed [19:0] r_temp_s5;
    logic [36:0]        r_sq5;
    t_corr              r_corr;

    logic signed [37:0] n_sq_full;
    logic [36:0]        n_sq5;
    logic signed [19:0] n_temp;
    logic               w_cold_s4;
    logic               w_cold_s5;
    t_corr              n_corr;

    assign w_cold_s4 = r_base_s4.dev[18];
    assign w_cold_s5 = r_base_s5.dev[18];

    always_comb begin
        n_sq_full = 38'(i_base.dev) * 38'(i_base.dev);
    end

    // 5*dev^2 and, in the cold branch, TEMP - T2
    always_comb begin
        n_sq5  = {2'b00, r_sq} + {r_sq, 2'b00};
        n_temp = w_cold_s4 ? (r_base_s4.temp - $signed({3'b000, r_base_s4.t2}))
                           : r_base_s4.temp;
    end

    always_comb begin
        n_corr.d1   = r_base_s5.d1;
        n_corr.off  = w_cold_s5 ? (r_base_s5.off - $signed({2'b00, r_sq5[36:1]}))
                                : r_base_s5.off;
        n_corr.sens = w_cold_s5 ? (r_base_s5.sens - $signed({3'b000, r_sq5[36:2]}))
                                : r_base_s5.sens;
        if (r_temp_s5 < TEMP_MIN) begin
            n_corr.temp         = TEMP_MIN[14:0];
            n_corr.temp_clamped = 1'b1;
        end else if (r_temp_s5 > TEMP_MAX) begin
            n_corr.temp         = TEMP_MAX[14:0];
            n_corr.temp_clamped = 1'b1;
        end else begin
            n_corr.temp         = r_temp_s5[14:0];
            n_corr.temp_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base_s4 <= i_base;
            r_sq      <= n_sq_full[34:0];
            r_base_s5 <= r_base_s4;
            r_temp_s5 <= n_temp;
            r_sq5     <= n_sq5;
            r_corr    <= n_corr;
        end
    end

    assign o_valid = r_v[2];
    assign o_corr  = r_corr;

endmodule

[rtl/bcomp_pressure.sv]
// pressure: split D1*SENS product, shifts and OFF subtraction, final clamp
// depends on bcomp_pkg and barometer_compensation_defines.svh
`include "barometer_compensation_defines.svh"

module bcomp_pressure
    import bcomp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_corr     i_corr,
    output logic      o_valid,
    output t_out_beat o_beat
);

    logic [3:0]         r_v;
    logic [42:0]        r_pl;
    logic signed [43:0] r_ph;
    t_corr              r_corr_s7;
    logic signed [41:0] r_q;
    t_corr              r_corr_s8;
    logic signed [27:0] r_pres;
    logic signed [14:0] r_temp_s9;
    logic               r_tclamp_s9;
    t_out_beat          r_out;

    logic [42:0]        n_pl;
    logic signed [43:0] n_ph;
    logic signed [62:0] n_prod;
    logic signed [42:0] n_x;
    t_out_beat          n_out;

    // sens split into unsigned low 19 bits and signed high part
    always_comb begin
        n_pl = 43'(i_corr.d1) * 43'(i_corr.sens[18:0]);
        n_ph = 44'($signed({1'b0, i_corr.d1})) * 44'($signed(i_corr.sens[37:19]));
    end

    always_comb begin
        n_prod = $signed({r_ph, 19'h00000}) + $signed({20'h00000, r_pl});
    end

    always_comb begin
        n_x = $signed({r_q[41], r_q}) - $signed({{5{r_corr_s8.off[37]}}, r_corr_s8.off});
    end

    always_comb begin
        n_out.temperature_centi = r_temp_s9;
        if (r_pres < PRES_MIN) begin
            n_out.pressure_centi_mbar = PRES_MIN[16:0];
            n_out.clamped             = 1'b1;
        end else if (r_pres > PRES_MAX) begin
            n_out.pressure_centi_mbar = PRES_MAX[16:0];
            n_out.clamped             = 1'b1;
        end else begin
            n_out.pressure_centi_mbar = r_pres[16:0];
            n_out.clamped             = r_tclamp_s9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl        <= n_pl;
            r_ph        <= n_ph;
            r_corr_s7   <= i_corr;
            r_q         <= n_prod[62:21];
            r_corr_s8   <= r_corr_s7;
            r_pres      <= n_x[42:15];
            r_temp_s9   <= r_corr_s8.temp;
            r_tclamp_s9 <= r_corr_s8.temp_clamped;
            r_out       <= n_out;
        end
    end

    assign o_valid = r_v[3];
    assign o_beat  = r_out;

    `BCOMP_ASSERT_IMPL(a_temp_range, i_clk, i_rst_n, o_valid, (o_beat.temperature_centi >= TEMP_MIN) && (o_beat.temperature_centi <= TEMP_MAX), "temperature out of range")
    `BCOMP_ASSERT_IMPL(a_pres_range, i_clk, i_rst_n, o_valid, (o_beat.pressure_centi_mbar >= PRES_MIN) && (o_beat.pressure_centi_mbar <= PRES_MAX), "pressure out of range")
    `BCOMP_ASSERT(a_flag_interior, i_clk, i_rst_n, o_valid && (o_beat.temperature_centi > TEMP_MIN) && (o_beat.temperature_centi < TEMP_MAX) && (o_beat.pressure_centi_mbar > PRES_MIN) && (o_beat.pressure_centi_mbar < PRES_MAX) |-> !o_beat.clamped, "clamp flag set on interior result")

endmodule

[rtl/barometer_compensation.sv]
// pipeline: 10 register stages, from the input beat to the output register
// throughput: one reading pair per cycle; a stalled output freezes every stage
// calibration words are read in the first three stages and must not change in flight
// reset (synchronous, active low) clears all stage valid bits and loads the
// calibration words with their factory defaults
module barometer_compensation
    import bcomp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_beat,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_coef r_coef;
    logic  w_en;
    logic  w_v_base;
    t_base w_base;
    logic  w_v_corr;
    t_corr w_corr;

    // pipeline moves whenever the output register is empty or being drained
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.pressure_sens   <= RST_PRESSURE_SENS;
            r_coef.pressure_offset <= RST_PRESSURE_OFFSET;
            r_coef.sens_tempco     <= RST_SENS_TEMPCO;
            r_coef.offset_tempco   <= RST_OFFSET_TEMPCO;
            r_coef.ref_temperature <= RST_REF_TEMPERATURE;
            r_coef.temp_slope      <= RST_TEMP_SLOPE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRESSURE_SENS:   r_coef.pressure_sens   <= i_cfg_wdata;
                CFG_PRESSURE_OFFSET: r_coef.pressure_offset <= i_cfg_wdata;
                CFG_SENS_TEMPCO:     r_coef.sens_tempco     <= i_cfg_wdata;
                CFG_OFFSET_TEMPCO:   r_coef.offset_tempco   <= i_cfg_wdata;
                CFG_REF_TEMPERATURE: r_coef.ref_temperature <= i_cfg_wdata;
                CFG_TEMP_SLOPE:      r_coef.temp_slope      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bcomp_first_order u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_beat  (i_in_beat),
        .i_coef  (r_coef),
        .o_valid (w_v_base),
        .o_base  (w_base)
    );

    bcomp_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v_base),
        .i_base  (w_base),
        .o_valid (w_v_corr),
        .o_corr  (w_corr)
    );

    bcomp_pressure u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v_corr),
        .i_corr  (w_corr),
        .o_valid (o_out_valid),
        .o_beat  (o_out_beat)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking bench for barometer_compensation: directed and random reading pairs,
// scored against a behavioral model of the compensation math; needs bcomp_pkg and the rtl
module testbench
    import bcomp_pkg::*;
();

    localparam int RESET_CYCLES       = 10;
    localparam int PIPE_LATENCY       = 10;
    localparam int READINGS_PER_SET   = 250;
    localparam int CAL_SETS           = 6;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT        = 200000;
    localparam int DIRECTED_COUNT     = 20;
    localparam int NOMINAL_REF_RAW    = 8566784;
    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

    localparam t_coef FACTORY_CAL = '{RST_PRESSURE_SENS, RST_PRESSURE_OFFSET, RST_SENS_TEMPCO,
                                      RST_OFFSET_TEMPCO, RST_REF_TEMPERATURE, RST_TEMP_SLOPE};

    typedef struct {
        int raw_p;
        int raw_t;
        bit typed;
        int temp;
        int pres;
        bit clamp;
    } reading_case_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_beat    i_in_beat;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_beat   o_out_beat;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    t_coef     cal_words;
    t_out_beat pending_results[$];
    int        sender_idle_pct;
    int        receiver_idle_pct;
    logic      hold_pending;
    int        cycle_count;
    int        mismatch_count;
    int        readings_sent;
    int        results_checked;
    int        clamped_results;

    reading_case_t directed_cases [0:DIRECTED_COUNT-1] = '{
        '{9085466, 8569150, 1'b1, 2007, 100009, 1'b0},      // typical operating point
        '{24'hFFFFFF, 24'hFFFFFF, 1'b1, 8500, 120000, 1'b1},
        '{0, 24'hFFFFFF, 1'b1, 8500, 1000, 1'b1},
        '{24'hFFFFFF, 0, 1'b1, -4000, 1000, 1'b1},
        '{0, 0, 1'b0, 0, 0, 1'b0},
        '{9085466, NOMINAL_REF_RAW, 1'b0, 0, 0, 1'b0},      // dT zero, exactly 20.00 degC
        '{9085466, 8566783, 1'b0, 0, 0, 1'b0},              // one count into the cold branch
        '{9085466, 7518208, 1'b0, 0, 0, 1'b0},
        '{9085466, 6469632, 1'b0, 0, 0, 1'b0},
        '{9085466, 9615360, 1'b0, 0, 0, 1'b0},
        '{9085466, 10663936, 1'b0, 0, 0, 1'b0},
        '{3800000, 8566784, 1'b0, 0, 0, 1'b0},
        '{4000000, 8566784, 1'b0, 0, 0, 1'b0},
        '{10000000, 8566784, 1'b0, 0, 0, 1'b0},
        '{10485760, 8566784, 1'b0, 0, 0, 1'b0},
        '{24'hAAAAAA, 24'h555555, 1'b0, 0, 0, 1'b0},
        '{24'h555555, 24'hAAAAAA, 1'b0, 0, 0, 1'b0},
        '{1, 1, 1'b0, 0, 0, 1'b0},
        '{24'h800000, 24'h7FFFFF, 1'b0, 0, 0, 1'b0},
        '{24'h7FFFFF, 24'h800000, 1'b0, 0, 0, 1'b0}
    };

    barometer_compensation DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // first and second order compensation with floor shifts, then saturation
    function automatic t_out_beat compensate_reading(input t_in_beat rd);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, pres, dev, sq5;
        t_out_beat res;
        d1 = longint'(rd.raw_pressure);
        d2 = longint'(rd.raw_temperature);
        c1 = longint'(cal_words.pressure_sens);
        c2 = longint'(cal_words.pressure_offset);
        c3 = longint'(cal_words.sens_tempco);
        c4 = longint'(cal_words.offset_tempco);
        c5 = longint'(cal_words.ref_temperature);
        c6 = longint'(cal_words.temp_slope);
        dt = d2 - c5 * 256;
        temp = longint'(TEMP_REF) + ((dt * c6) >>> 23);
        off = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        // cold branch is picked before T2 comes off
        if (temp < longint'(TEMP_REF)) begin
            dev = temp - longint'(TEMP_REF);
            sq5 = 5 * dev * dev;
            temp = temp - ((dt * dt) >>> 31);
            off = off - (sq5 >>> 1);
            sens = sens - (sq5 >>> 2);
        end
        pres = (((d1 * sens) >>> 21) - off) >>> 15;
        res.clamped = 1'b0;
        if (temp < longint'(TEMP_MIN)) begin
            temp = longint'(TEMP_MIN);
            res.clamped = 1'b1;
        end
        if (temp > longint'(TEMP_MAX)) begin
            temp = longint'(TEMP_MAX);
            res.clamped = 1'b1;
        end
        if (pres < longint'(PRES_MIN)) begin
            pres = longint'(PRES_MIN);
            res.clamped = 1'b1;
        end
        if (pres > longint'(PRES_MAX)) begin
            pres = longint'(PRES_MAX);
            res.clamped = 1'b1;
        end
        res.temperature_centi = temp[14:0];
        res.pressure_centi_mbar = pres[16:0];
        return res;
    endfunction

    // mostly readings near the reference temperature so the cold branch and
    // in-range pressures show up; the rest spans the full 24 bits
    function automatic t_in_beat random_reading();
        t_in_beat rd;
        int span;
        int raw_t;
        if ($urandom_range(0, 3) == 0) begin
            rd.raw_pressure = 24'($urandom());
            rd.raw_temperature = 24'($urandom());
        end else begin
            case ($urandom_range(0, 3))
                0: span = 1 << 12;
                1: span = 1 << 17;
                2: span = 1 << 20;
                default: span = 1 << 22;
            endcase
            raw_t = int'(cal_words.ref_temperature) * 256
                  + int'($urandom_range(0, 2 * span)) - span;
            if (raw_t < 0)
                raw_t = 0;
            if (raw_t > 'hFFFFFF)
                raw_t = 'hFFFFFF;
            rd.raw_temperature = raw_t[23:0];
            if ($urandom_range(0, 1) == 0)
                rd.raw_pressure = 24'($urandom_range(3000000, 12000000));
            else
                rd.raw_pressure = 24'($urandom());
        end
        return rd;
    endfunction

    function automatic t_coef random_calibration(input bit favor_extremes);
        t_coef c;
        logic [15:0] words [6];
        for (int k = 0; k < 6; k++) begin
            case (favor_extremes ? $urandom_range(0, 2) : 2)
                0: words[k] = 16'h0000;
                1: words[k] = 16'hFFFF;
                default: words[k] = 16'($urandom_range(0, 65535));
            endcase
        end
        c = '{words[0], words[1], words[2], words[3], words[4], words[5]};
        return c;
    endfunction

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // writes go in only with the pipeline empty
    task automatic load_calibration(input t_coef c, input bit poke_unused);
        logic [15:0] word;
        wait_for_drain();
        for (int r = int'(CFG_PRESSURE_SENS); r <= int'(CFG_TEMP_SLOPE); r++) begin
            case (t_cfg_idx'(r))
                CFG_PRESSURE_SENS:   word = c.pressure_sens;
                CFG_PRESSURE_OFFSET: word = c.pressure_offset;
                CFG_SENS_TEMPCO:     word = c.sens_tempco;
                CFG_OFFSET_TEMPCO:   word = c.offset_tempco;
                CFG_REF_TEMPERATURE: word = c.ref_temperature;
                default:             word = c.temp_slope;
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= r[2:0];
            i_cfg_wdata <= word;
            @(posedge i_clk);
        end
        // writes to the spare indexes must leave every word alone
        if (poke_unused) begin
            i_cfg_idx <= CFG_UNUSED_LO;
            i_cfg_wdata <= 16'($urandom_range(0, 65535));
            @(posedge i_clk);
            i_cfg_idx <= CFG_UNUSED_HI;
            i_cfg_wdata <= 16'($urandom_range(0, 65535));
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cal_words = c;
    endtask

    // returns at the edge where the beat was taken; valid is left as it is
    task automatic offer_reading(input t_in_beat rd, input bit typed, input t_out_beat want);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= rd;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(typed ? want : compensate_reading(rd));
        readings_sent++;
    endtask

    task automatic run_readings(input int count);
        for (int k = 0; k < count; k++)
            offer_reading(random_reading(), 1'b0, '0);
        i_in_valid <= 1'b0;
        wait_for_drain();
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending <= 1'b0;
                i_out_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_beat);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_beat.clamped)
                    clamped_results++;
                if (o_out_beat.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi: expected %0d, got %0d",
                           want.temperature_centi, o_out_beat.temperature_centi);
                    mismatch_count++;
                end
                if (o_out_beat.pressure_centi_mbar !== want.pressure_centi_mbar) begin
                    $error("pressure_centi_mbar: expected %0d, got %0d",
                           want.pressure_centi_mbar, o_out_beat.pressure_centi_mbar);
                    mismatch_count++;
                end
                if (o_out_beat.clamped !== want.clamped) begin
                    $error("clamped: expected %0b, got %0b", want.clamped, o_out_beat.clamped);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_in_beat  rd;
        t_out_beat want;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        hold_pending = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        readings_sent = 0;
        results_checked = 0;
        clamped_results = 0;
        sender_idle_pct = 11;
        receiver_idle_pct = 48;
        cal_words = FACTORY_CAL;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed readings against the factory calibration
        foreach (directed_cases[k]) begin
            rd.raw_pressure = directed_cases[k].raw_p[23:0];
            rd.raw_temperature = directed_cases[k].raw_t[23:0];
            want.temperature_centi = directed_cases[k].temp[14:0];
            want.pressure_centi_mbar = directed_cases[k].pres[16:0];
            want.clamped = directed_cases[k].clamp;
            offer_reading(rd, directed_cases[k].typed, want);
        end
        i_in_valid <= 1'b0;

        for (int set = 0; set < CAL_SETS; set++) begin
            case (set)
                0: load_calibration(random_calibration(1'b0), 1'b0);
                1: load_calibration('0, 1'b0);
                2: load_calibration('1, 1'b0);
                3: load_calibration(FACTORY_CAL, 1'b1);
                4: load_calibration(random_calibration(1'b0), 1'b1);
                default: load_calibration(random_calibration(1'b1), 1'b0);
            endcase
            if (set < 2) begin
                sender_idle_pct = 11;
                receiver_idle_pct = 48;
            end else if (set < 4) begin
                sender_idle_pct = 48;
                receiver_idle_pct = 11;
            end else begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            // back up the pipeline while the sender keeps pushing
            if (set == 4)
                hold_pending <= 1'b1;
            run_readings(READINGS_PER_SET);
        end

        wait_for_drain();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        $display("%0d reading pairs sent over %0d calibration sets, %0d results scored",
                 readings_sent, CAL_SETS + 1, results_checked);
        $display("%0d results saturated, %0d mismatches", clamped_results, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
